### src/stns_pkg.sv
// stns_pkg: shared widths, field codes and register indexes for the
// sorted table nearest search block; no dependencies
package stns_pkg;

    localparam int IDX_W      = 10;   // entry_index / nearest_index / first_index
    localparam int LAST_W     = 11;   // last_index, signed
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int OUT_DATA_W = 16;   // nearest_index padded to whole bytes

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_INDEX = 1'b0,
        CFG_LAST_INDEX  = 1'b1
    } cfg_reg_t;

    typedef enum logic [0:0] {
        FUNC_WRITE  = 1'b0,
        FUNC_SEARCH = 1'b1
    } func_t;

    // midpoint of an index range, lo <= hi
    function automatic logic [IDX_W-1:0] mid_of(input logic [IDX_W-1:0] lo,
                                                input logic [IDX_W-1:0] hi);
        logic [IDX_W:0] sum;
        sum = {1'b0, lo} + {1'b0, hi};
        return sum[IDX_W:1];
    endfunction

endpackage

### src/sorted_table_nearest_search.sv
// sorted_table_nearest_search: table of signed fixed point entries with a
// binary search for the nearest entry; uses stns_pkg and stns_ram
//
//   channel   direction  payload
//   s_*       in         tuser: func; tdata: entry_index [9:0], value above
//   m_*       out        tuser: not_found; tdata: nearest_index [9:0]
//   cfg_*     in         cfg_index selects first_index or last_index
//
// a write request is taken while idle and the block stays ready
// a search probes the table once per binary search step (at most log2 of the
// window plus one probes), reads the entry below when needed, then loads
// the result; all reads go through the single ram read port
// the block takes no request while a search runs or a result waits to load
// the table is not cleared by reset; first_index and last_index reset to 0, 1023
module sorted_table_nearest_search
    import stns_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32,
    localparam int S_DATA_W   = ((IDX_W + VALUE_WIDTH + 7) / 8) * 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,    // entry_index, value
    input  logic                  s_tuser,    // func
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,    // nearest_index
    output logic                  m_tuser,    // not_found
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int WW = (AW > IDX_W) ? AW : IDX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_BELOW,
        S_DONE
    } state_t;

    state_t                    state_reg, state_next;
    logic [IDX_W-1:0]          lo_reg, lo_next;
    logic [IDX_W-1:0]          hi_reg, hi_next;
    logic [IDX_W-1:0]          mid_reg, mid_next;
    logic [VALUE_WIDTH-1:0]    key_reg, key_next;
    logic [VALUE_WIDTH-1:0]    upper_reg, upper_next;
    logic [IDX_W-1:0]          ans_reg, ans_next;
    logic                      nf_reg, nf_next;
    logic                      m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]          m_idx_reg, m_idx_next;
    logic                      m_nf_reg, m_nf_next;
    logic [IDX_W-1:0]          first_reg;
    logic [LAST_W-1:0]         last_reg;

    logic                      in_acc;
    logic [IDX_W-1:0]          in_entry;
    logic [VALUE_WIDTH-1:0]    in_value;
    logic signed [31:0]        first32, last32, lim32, hi_eff32;
    logic                      win_empty;
    logic [IDX_W-1:0]          hi_start;

    logic                      ram_we, ram_re;
    logic [IDX_W-1:0]          rd_idx;
    logic [WW-1:0]             rd_wide, wr_wide;
    logic [AW-1:0]             ram_raddr, ram_waddr;
    logic [VALUE_WIDTH-1:0]    ram_rdata;

    logic                      eq, gt;
    logic signed [VALUE_WIDTH:0] diff_m, diff_b;
    logic [VALUE_WIDTH:0]      dist_m, dist_b;

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign in_entry = s_tdata[IDX_W-1:0];
    assign in_value = s_tdata[IDX_W +: VALUE_WIDTH];

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_DATA_W'(m_idx_reg);
    assign m_tuser  = m_nf_reg;

    // effective window: last clamped to the table end
    assign first32   = $signed({22'd0, first_reg});
    assign last32    = 32'(signed'(last_reg));
    assign lim32     = 32'(TABLE_DEPTH - 1);
    assign hi_eff32  = (last32 > lim32) ? lim32 : last32;
    assign win_empty = (hi_eff32 < first32);
    assign hi_start  = hi_eff32[IDX_W-1:0];

    assign ram_we = in_acc && (func_t'(s_tuser) == FUNC_WRITE)
                    && (32'(in_entry) < 32'(TABLE_DEPTH));
    assign wr_wide   = WW'(in_entry);
    assign ram_waddr = wr_wide[AW-1:0];
    assign rd_wide   = WW'(rd_idx);
    assign ram_raddr = rd_wide[AW-1:0];

    stns_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (TABLE_DEPTH),
        .ADDR_W(AW)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(in_value),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign eq = (ram_rdata == key_reg);
    assign gt = ($signed(ram_rdata) > $signed(key_reg));

    // distances at one bit wider than the values, so they never wrap
    assign diff_m = $signed({upper_reg[VALUE_WIDTH-1], upper_reg})
                    - $signed({key_reg[VALUE_WIDTH-1], key_reg});
    assign diff_b = $signed({ram_rdata[VALUE_WIDTH-1], ram_rdata})
                    - $signed({key_reg[VALUE_WIDTH-1], key_reg});
    assign dist_m = diff_m[VALUE_WIDTH] ? $unsigned(-diff_m) : $unsigned(diff_m);
    assign dist_b = diff_b[VALUE_WIDTH] ? $unsigned(-diff_b) : $unsigned(diff_b);

    always_comb
    begin
        state_next   = state_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        key_next     = key_reg;
        upper_next   = upper_reg;
        ans_next     = ans_reg;
        nf_next      = nf_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_idx_next   = m_idx_reg;
        m_nf_next    = m_nf_reg;
        ram_re       = 1'b0;
        rd_idx       = mid_of(first_reg, hi_start);

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (func_t'(s_tuser) == FUNC_SEARCH))
                begin
                    key_next = in_value;
                    if (win_empty)
                    begin
                        ans_next   = '0;
                        nf_next    = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        lo_next    = first_reg;
                        hi_next    = hi_start;
                        mid_next   = rd_idx;
                        ram_re     = 1'b1;
                        state_next = S_CMP;
                    end
                end
            end
            S_CMP:
            begin
                nf_next = 1'b0;
                if (eq)
                begin
                    ans_next   = mid_reg;
                    state_next = S_DONE;
                end
                else if (gt)
                begin
                    if (mid_reg == lo_reg)
                    begin
                        if (mid_reg != '0)
                        begin
                            // compare against the entry just below
                            upper_next = ram_rdata;
                            rd_idx     = mid_reg - 1'b1;
                            ram_re     = 1'b1;
                            state_next = S_BELOW;
                        end
                        else
                        begin
                            ans_next   = mid_reg;
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        hi_next  = mid_reg - 1'b1;
                        rd_idx   = mid_of(lo_reg, mid_reg - 1'b1);
                        mid_next = rd_idx;
                        ram_re   = 1'b1;
                    end
                end
                else
                begin
                    if (mid_reg == hi_reg)
                    begin
                        ans_next   = hi_reg;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        lo_next  = mid_reg + 1'b1;
                        rd_idx   = mid_of(mid_reg + 1'b1, hi_reg);
                        mid_next = rd_idx;
                        ram_re   = 1'b1;
                    end
                end
            end
            S_BELOW:
            begin
                // tie keeps the upper entry
                ans_next   = (dist_b < dist_m) ? (mid_reg - 1'b1) : mid_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_idx_next   = ans_reg;
                    m_nf_next    = nf_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            lo_reg      <= '0;
            hi_reg      <= '0;
            mid_reg     <= '0;
            key_reg     <= '0;
            upper_reg   <= '0;
            ans_reg     <= '0;
            nf_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            m_idx_reg   <= '0;
            m_nf_reg    <= 1'b0;
            first_reg   <= '0;
            last_reg    <= LAST_W'(1023);
        end
        else
        begin
            state_reg   <= state_next;
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            mid_reg     <= mid_next;
            key_reg     <= key_next;
            upper_reg   <= upper_next;
            ans_reg     <= ans_next;
            nf_reg      <= nf_next;
            m_valid_reg <= m_valid_next;
            m_idx_reg   <= m_idx_next;
            m_nf_reg    <= m_nf_next;
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_FIRST_INDEX: first_reg <= cfg_wdata[IDX_W-1:0];
                    CFG_LAST_INDEX:  last_reg  <= cfg_wdata[LAST_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    // probe always inside the current range
    a_mid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (lo_reg <= mid_reg) && (mid_reg <= hi_reg))
        else $error("search probe outside its range");

    // an empty window reports index zero
    a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_nf_reg) |-> (m_idx_reg == '0))
        else $error("not_found result with nonzero index");

    // a result only comes out of a finished search
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result without a finished search");

    // a write request never starts a search
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (func_t'(s_tuser) == FUNC_WRITE)) |=> (state_reg == S_IDLE))
        else $error("write request left idle");

    // the entry below is read only from the low end of a range
    a_below_src: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BELOW) |-> ($past(state_reg) == S_CMP) && (mid_reg != '0))
        else $error("below compare without a low end hit");

endmodule

### src/stns_ram.sv
// stns_ram: generic single write port, single read port ram with a
// registered read; no dependencies
module stns_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### tb/sorted_table_nearest_search_test.sv
// sorted_table_nearest_search_test: self-checking bench for the nearest entry search,
// loads a sorted table, then runs directed and random requests under several windows
// depends on stns_pkg and sorted_table_nearest_search
module sorted_table_nearest_search_test;
    import stns_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH   = 1024;
    localparam int VALUE_WIDTH   = 32;
    localparam int S_DATA_W      = ((IDX_W + VALUE_WIDTH + 7) / 8) * 8;
    localparam int LOAD_N        = 512;     // entries loaded; every window stays below this
    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 4000;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic             not_found;
        logic [IDX_W-1:0] index;
    } answer_t;

    class nearest_scoreboard;
        logic signed [VALUE_WIDTH-1:0] entries [TABLE_DEPTH];
        logic [IDX_W-1:0]              win_first;
        logic signed [LAST_W-1:0]      win_last;
        answer_t                       pending_q [$];
        int                            mismatches;

        function new();
            win_first  = '0;
            win_last   = 11'sd1023;
            mismatches = 0;
        endfunction

        function void set_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] d);
            if (r == CFG_FIRST_INDEX)
                win_first = d[IDX_W-1:0];
            else
                win_last = d[LAST_W-1:0];
        endfunction

        function int outstanding();
            return pending_q.size();
        endfunction

        // binary search with the nearest-neighbor pick at the left end
        function answer_t nearest_of(logic signed [VALUE_WIDTH-1:0] key);
            int      lo;
            int      hi;
            int      mid;
            bit      done;
            longint  k;
            longint  m;
            longint  below;
            longint  d_mid;
            longint  d_below;
            answer_t ans;
            lo = win_first;
            hi = win_last;
            if (hi > TABLE_DEPTH - 1)
                hi = TABLE_DEPTH - 1;
            ans = '0;
            if (hi < lo)
            begin
                ans.not_found = 1'b1;
                return ans;
            end
            k = key;
            done = 1'b0;
            while (!done)
            begin
                mid = (lo + hi) / 2;
                m = entries[mid];
                if (m == k)
                    done = 1'b1;
                else if (m > k)
                begin
                    if (mid == lo)
                    begin
                        if (mid > 0)
                        begin
                            below   = entries[mid-1];
                            d_below = (below >= k) ? below - k : k - below;
                            d_mid   = m - k;
                            if (d_below < d_mid)
                                mid = mid - 1;
                        end
                        done = 1'b1;
                    end
                    else
                        hi = mid - 1;
                end
                else
                begin
                    if (mid == hi)
                        done = 1'b1;
                    else
                        lo = mid + 1;
                end
            end
            ans.index = mid[IDX_W-1:0];
            return ans;
        endfunction

        function void note_request(func_t f, logic [IDX_W-1:0] pos,
                                   logic signed [VALUE_WIDTH-1:0] val);
            if (f == FUNC_WRITE)
                entries[pos] = val;
            else
                pending_q.push_back(nearest_of(val));
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] tdata, logic tuser);
            answer_t want;
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: tdata %0h tuser %0b", tdata, tuser);
                return;
            end
            want = pending_q.pop_front();
            if (tdata !== OUT_DATA_W'(want.index) || tuser !== want.not_found)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("mismatch: expected index %0d not_found %0b, got tdata %0h tuser %0b",
                             want.index, want.not_found, tdata, tuser);
            end
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    nearest_scoreboard sb = new();
    bit quiet    = 1'b0;
    bit hold_req = 1'b0;
    int cur_first = 0;
    int cur_last  = LOAD_N - 1;
    int idle_cycles = 0;

    sorted_table_nearest_search #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // offer one request, with an occasional idle burst ahead of it
    task automatic send_request(func_t f, logic [IDX_W-1:0] pos,
                                logic signed [VALUE_WIDTH-1:0] val);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {{(S_DATA_W - IDX_W - VALUE_WIDTH){1'b0}}, val, pos};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(f, pos, val);
    endtask

    // drain the block, let a trailing search settle, then write both window registers
    task automatic set_window(int first, int last);
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FIRST_INDEX;
        cfg_wdata <= CFG_DATA_W'(first);
        @(posedge clk);
        sb.set_reg(CFG_FIRST_INDEX, CFG_DATA_W'(first));
        cfg_index <= CFG_LAST_INDEX;
        cfg_wdata <= CFG_DATA_W'(last);
        @(posedge clk);
        sb.set_reg(CFG_LAST_INDEX, CFG_DATA_W'(last));
        cfg_we    <= 1'b0;
        cur_first = first;
        cur_last  = last;
    endtask

    // result side: random stalls, one long hold on request
    initial
    begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 4) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        int     phase_items [9] = '{50, 20, 20, 35, 15, 40, 20, 30, 50};
        int     i;
        int     n;
        int     p;
        int     r;
        int     a_idx;
        int     b_idx;
        longint acc;
        longint a;
        longint b;
        longint t;
        longint v;
        logic signed [VALUE_WIDTH-1:0] saved;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ascending table, even steps at even indices so some midpoints tie
        acc = -64'sd2147483648 + $urandom_range(1, 3000);
        for (i = 0; i < LOAD_N; i++)
        begin
            if (i > 0)
            begin
                if ($urandom_range(0, 15) == 0)
                    t = $urandom_range(0, 2);
                else
                    t = $urandom_range(2, 14000000);
                if (i % 2 == 0)
                    t = t & ~64'sd1;
                acc = acc + t;
                if (acc > 64'sd2147483646)
                    acc = 64'sd2147483646;
            end
            send_request(FUNC_WRITE, i[IDX_W-1:0], acc[VALUE_WIDTH-1:0]);
        end

        // directed: full loaded window, extremes below and above the table, exact hits
        set_window(0, LOAD_N - 1);
        send_request(FUNC_SEARCH, '0, 32'sh80000000);
        send_request(FUNC_SEARCH, '1, 32'sh7fffffff);
        send_request(FUNC_SEARCH, 10'd0, sb.entries[0]);
        send_request(FUNC_SEARCH, IDX_W'(LOAD_N - 1), sb.entries[LOAD_N-1]);
        send_request(FUNC_SEARCH, IDX_W'(LOAD_N / 2), sb.entries[LOAD_N/2]);
        // tie at an exact midpoint goes to the upper entry
        for (i = 0; i < LOAD_N - 1; i++)
        begin
            a = sb.entries[i];
            b = sb.entries[i+1];
            if (b - a >= 4 && (b - a) % 2 == 0)
                break;
        end
        send_request(FUNC_SEARCH, '0, VALUE_WIDTH'((a + b) / 2));
        send_request(FUNC_SEARCH, '0, VALUE_WIDTH'((a + b) / 2 - 1));
        send_request(FUNC_SEARCH, '0, VALUE_WIDTH'((a + b) / 2 + 1));

        // entry below the window wins when nearer
        set_window(300, 450);
        a = sb.entries[299];
        b = sb.entries[300];
        send_request(FUNC_SEARCH, '0, VALUE_WIDTH'(a + (b - a) / 4));
        send_request(FUNC_SEARCH, '0, sb.entries[450]);

        set_window(0, LOAD_N - 1);
        send_request(FUNC_WRITE, 10'd0, 32'sh80000000);
        send_request(FUNC_WRITE, IDX_W'(LOAD_N - 1), 32'sh7fffffff);
        send_request(FUNC_SEARCH, '0, 32'sh80000000);
        send_request(FUNC_SEARCH, '0, 32'sh7fffffff);
        // duplicate neighbors
        send_request(FUNC_WRITE, 10'd401, sb.entries[400]);
        send_request(FUNC_SEARCH, '0, sb.entries[400]);
        // out of order entry, then put it back
        saved = sb.entries[200];
        send_request(FUNC_WRITE, 10'd200, $urandom);
        send_request(FUNC_SEARCH, '0, sb.entries[200]);
        send_request(FUNC_SEARCH, '0, saved);
        send_request(FUNC_WRITE, 10'd200, saved);

        set_window(0, 0);
        send_request(FUNC_SEARCH, '0, 32'sh7fffffff);
        set_window(LOAD_N - 1, LOAD_N - 1);
        send_request(FUNC_SEARCH, '0, 32'sh80000000);
        send_request(FUNC_SEARCH, '0, 32'sh7fffffff);
        // empty windows
        set_window(5, 4);
        send_request(FUNC_SEARCH, '0, sb.entries[5]);
        set_window(0, -1);
        send_request(FUNC_SEARCH, '1, 32'sh00000000);

        for (p = 0; p < 9; p++)
        begin
            case (p)
                0, 8: set_window(0, LOAD_N - 1);
                1: set_window(0, 0);
                2: set_window(LOAD_N - 1, LOAD_N - 1);
                3:
                begin
                    a_idx = $urandom_range(0, LOAD_N - 1);
                    b_idx = a_idx + $urandom_range(0, 15);
                    if (b_idx > LOAD_N - 1)
                        b_idx = LOAD_N - 1;
                    set_window(a_idx, b_idx);
                end
                4: set_window(0, -1);
                6: set_window(1, 1);
                default:
                begin
                    a_idx = $urandom_range(0, LOAD_N - 1);
                    b_idx = $urandom_range(a_idx, LOAD_N - 1);
                    set_window(a_idx, b_idx);
                end
            endcase
            if (p == 8)
                quiet = 1'b1;
            for (n = 0; n < phase_items[p]; n++)
            begin
                if (p == 5 && n == 20)
                    hold_req = 1'b1;
                r = $urandom_range(0, 99);
                if (cur_last >= cur_first && $urandom_range(0, 3) != 0)
                    i = $urandom_range(cur_first, cur_last);
                else
                    i = $urandom_range(0, LOAD_N - 1);
                if (r < 22)
                begin
                    // write that keeps the order with its neighbors
                    a = (i == 0) ? -64'sd2147483648 : longint'(sb.entries[i-1]);
                    b = (i == LOAD_N - 1) ? 64'sd2147483647 : longint'(sb.entries[i+1]);
                    if (a > b)
                        v = longint'($signed($urandom));
                    else
                        v = a + longint'($urandom) % (b - a + 1);
                    send_request(FUNC_WRITE, i[IDX_W-1:0], v[VALUE_WIDTH-1:0]);
                end
                else if (r < 25)
                    send_request(FUNC_WRITE, i[IDX_W-1:0], $urandom);
                else if (r < 50)
                    send_request(FUNC_SEARCH, IDX_W'($urandom), sb.entries[i]);
                else if (r < 75)
                begin
                    if (i == LOAD_N - 1)
                        i = LOAD_N - 2;
                    a = sb.entries[i];
                    b = sb.entries[i+1];
                    if (a > b)
                    begin
                        t = a;
                        a = b;
                        b = t;
                    end
                    if ((b - a) % 2 == 0 && $urandom_range(0, 2) == 0)
                        v = (a + b) / 2;
                    else
                        v = a + longint'($urandom) % (b - a + 1);
                    send_request(FUNC_SEARCH, IDX_W'($urandom), v[VALUE_WIDTH-1:0]);
                end
                else if (r < 88)
                    send_request(FUNC_SEARCH, IDX_W'($urandom), $urandom);
                else
                begin
                    case ($urandom_range(0, 3))
                        0: v = -64'sd2147483648;
                        1: v = 64'sd2147483647;
                        2: v = -64'sd2147483648 + $urandom_range(0, 5000);
                        default: v = 64'sd2147483647 - $urandom_range(0, 5000);
                    endcase
                    send_request(FUNC_SEARCH, IDX_W'($urandom), v[VALUE_WIDTH-1:0]);
                end
            end
        end

        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
